### rtl/articulation_point_finder_macros.svh
// assertion macros for the articulation point finder
// used by the top level; expects clk_i and rst_ni in scope
`ifndef ARTICULATION_POINT_FINDER_MACROS_SVH
`define ARTICULATION_POINT_FINDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define APF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define APF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/apf_pkg.sv
// shared types and constants of the articulation point finder
// no dependencies
package apf_pkg;

  localparam int NODE_W = 7;
  localparam logic [NODE_W-1:0] VCNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_CLEAR = 2'd2
  } act_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WA,
    S_ADD_WB,
    S_ROOT,
    S_ROW,
    S_SCAN,
    S_ET,
    S_POP,
    S_POP_RD,
    S_POP_PAR,
    S_EMIT
  } state_e;

endpackage

### rtl/apf_if.sv
// request and result channel interfaces of the articulation point finder
// depends on apf_pkg
interface apf_req_if import apf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  modport source (output valid, action, node_a, node_b, input ready);
  modport sink (input valid, action, node_a, node_b, output ready);
endinterface

interface apf_res_if import apf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] vertex;
  logic              found;
  logic [NODE_W-1:0] count;
  logic              last;
  modport source (output valid, vertex, found, count, last, input ready);
  modport sink (input valid, vertex, found, count, last, output ready);
endinterface

### rtl/articulation_point_finder.sv
// articulation point finder: top level with sequencer and walk datapath
// depends on apf_pkg, apf_if, apf_ram and articulation_point_finder_macros.svh
//
// Usage: requests arrive on req_i (action, node_a, node_b). An add request
// sets one undirected edge in an adjacency ram. A clear request empties
// the graph through per-row valid bits. A run request walks the graph
// depth first under a small sequencer that steps one neighbor a cycle
// while no descend, return or S_ET step for a visited neighbor holds it,
// and then emits every cut vertex in ascending order on res_o, each with
// the total count; with none it emits one item, found=0. The run time
// grows with the scan over each adjacency row, the S_ET step for each
// neighbor found already visited, the ram read on every descend and
// return, and the root and emit sweeps; req_i.ready is low for the whole
// run. The vertex_count register is written with cfg_we_i / cfg_wdata_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Reset clears the graph, the control state and
// sets vertex_count to 64; no clearing pass is needed. When the receiver
// stalls, the result register holds and the emit sweep waits.
`include "articulation_point_finder_macros.svh"

module articulation_point_finder import apf_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  apf_req_if.sink           req_i,
  apf_res_if.source         res_o
);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int FW = IW + 3 * CW;
  localparam logic [CW-1:0] SP_MAX = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] C_ONE = CW'(1);
  localparam logic [CW-1:0] C_TWO = CW'(2);
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

  state_e state_q, state_d;

  logic [NODE_W-1:0]       vcnt_q;
  logic [CW-1:0]           eff_n;
  logic [MAX_VERTICES-1:0] row_vld_q, visited_q, cut_q;
  logic                    adj_vld_rd_q;
  logic [IW-1:0]           a_idx_q, b_idx_q;
  logic [CW-1:0]           sp_q, clk_q, cnt_q, rv_q, ev_q, k_q;
  logic [1:0]              rc_q;
  logic [IW-1:0]           cur_v_q, par_v_q;
  logic                    has_par_q;
  logic [CW-1:0]           cur_scan_q, cur_low_q, cur_entry_q;
  logic [MAX_VERTICES-1:0] cur_row_q;
  logic                    out_vld_q, found_q, last_q;
  logic [NODE_W-1:0]       vertex_q, count_q;

  // ram ports
  logic                    adj_we, adj_re, fr_we, fr_re, et_we, et_re;
  logic [IW-1:0]           adj_waddr, adj_raddr, fr_waddr, fr_raddr, et_waddr, et_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, adj_row;
  logic [FW-1:0]           fr_wdata, fr_rdata;
  logic [CW-1:0]           et_wdata, et_rdata;

  // decoded helpers
  logic          req_fire, add_ok, out_load, out_set;
  logic [IW-1:0] w_idx, rv_idx, ev_idx, fr_v;
  logic [CW-1:0] fr_low, fr_entry, fr_scan, clk_inc;
  logic          scan_end, skip_w, w_vis, rv_end, ev_end;

  assign eff_n = (vcnt_q > NODE_W'(MAX_VERTICES)) ? SP_MAX : CW'(vcnt_q);
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire = req_i.valid && req_i.ready;
  assign add_ok = (req_i.node_a != '0) && (req_i.node_b != '0) &&
                  (req_i.node_a <= NODE_W'(eff_n)) && (req_i.node_b <= NODE_W'(eff_n));
  assign out_load = !out_vld_q || res_o.ready;

  assign w_idx    = IW'(cur_scan_q);
  assign rv_idx   = IW'(rv_q);
  assign ev_idx   = IW'(ev_q);
  assign scan_end = cur_scan_q >= eff_n;
  assign rv_end   = rv_q >= eff_n;
  assign ev_end   = ev_q >= eff_n;
  assign skip_w   = !cur_row_q[w_idx] || (has_par_q && (w_idx == par_v_q));
  assign w_vis    = visited_q[w_idx];
  assign clk_inc  = clk_q + C_ONE;
  assign adj_row  = adj_vld_rd_q ? adj_rdata : '0;
  assign out_set  = (state_q == S_EMIT) && out_load &&
                    ((cnt_q == '0) || (!ev_end && cut_q[ev_idx]));

  assign fr_v     = fr_rdata[FW-1 -: IW];
  assign fr_scan  = fr_rdata[3*CW-1 -: CW];
  assign fr_low   = fr_rdata[2*CW-1 -: CW];
  assign fr_entry = fr_rdata[CW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          priority case (req_i.action)
            ACT_ADD: state_d = add_ok ? S_ADD_WA : S_IDLE;
            ACT_RUN: state_d = S_ROOT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_WA:  state_d = S_ADD_WB;
      S_ADD_WB:  state_d = S_IDLE;
      S_ROOT: begin
        if (rv_end) begin
          state_d = S_EMIT;
        end else if (!visited_q[rv_idx]) begin
          state_d = S_ROW;
        end
      end
      S_ROW:     state_d = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_POP;
        end else if (!skip_w) begin
          state_d = w_vis ? S_ET : S_ROW;
        end
      end
      S_ET:      state_d = S_SCAN;
      S_POP:     state_d = (sp_q == C_ONE) ? S_ROOT : S_POP_RD;
      S_POP_RD:  state_d = S_POP_PAR;
      S_POP_PAR: state_d = S_SCAN;
      S_EMIT: begin
        if (cnt_q == '0) begin
          if (out_load) state_d = S_IDLE;
        end else if (ev_end) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // ram controls
  always_comb begin
    adj_we = 1'b0; adj_waddr = a_idx_q; adj_wdata = adj_row | (ROW_ONE << b_idx_q);
    adj_re = 1'b0; adj_raddr = rv_idx;
    fr_we = 1'b0;  fr_waddr = IW'(sp_q - C_ONE);
    fr_wdata = {cur_v_q, cur_scan_q + C_ONE, cur_low_q, cur_entry_q};
    fr_re = 1'b0;  fr_raddr = IW'(sp_q - C_TWO);
    et_we = 1'b0;  et_waddr = rv_idx; et_wdata = clk_inc;
    et_re = 1'b0;  et_raddr = w_idx;
    unique case (state_q)
      S_IDLE: begin
        adj_re = req_fire && (req_i.action == ACT_ADD) && add_ok;
        adj_raddr = IW'(req_i.node_a - NODE_W'(1));
      end
      S_ADD_WA: begin
        adj_we = 1'b1;
        adj_re = 1'b1;
        adj_raddr = b_idx_q;
      end
      S_ADD_WB: begin
        adj_we = 1'b1;
        adj_waddr = b_idx_q;
        adj_wdata = adj_row | (ROW_ONE << a_idx_q);
      end
      S_ROOT: begin
        adj_re = !rv_end && !visited_q[rv_idx];
        et_we  = adj_re;
      end
      S_SCAN: begin
        if (!scan_end && !skip_w) begin
          if (w_vis) begin
            et_re = 1'b1;
          end else begin
            fr_we = 1'b1;
            et_we = 1'b1;
            et_waddr = w_idx;
            adj_re = 1'b1;
            adj_raddr = w_idx;
          end
        end
      end
      S_POP: fr_re = (sp_q != C_ONE);
      S_POP_RD: begin
        adj_re = 1'b1;
        adj_raddr = fr_v;
        fr_re = (sp_q >= C_TWO);
      end
      default: ;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q <= VCNT_RESET;
      row_vld_q <= '0; visited_q <= '0; cut_q <= '0;
      adj_vld_rd_q <= 1'b0;
      a_idx_q <= '0; b_idx_q <= '0;
      sp_q <= '0; clk_q <= '0; cnt_q <= '0; rv_q <= '0; ev_q <= '0; k_q <= '0;
      rc_q <= '0;
      cur_v_q <= '0; par_v_q <= '0; has_par_q <= 1'b0;
      cur_scan_q <= '0; cur_low_q <= '0; cur_entry_q <= '0; cur_row_q <= '0;
      out_vld_q <= 1'b0; found_q <= 1'b0; last_q <= 1'b0;
      vertex_q <= '0; count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      if (adj_re) adj_vld_rd_q <= row_vld_q[adj_raddr];
      if (adj_we) row_vld_q[adj_waddr] <= 1'b1;
      if (out_set) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            priority case (req_i.action)
              ACT_ADD: begin
                a_idx_q <= IW'(req_i.node_a - NODE_W'(1));
                b_idx_q <= IW'(req_i.node_b - NODE_W'(1));
              end
              ACT_RUN: begin
                visited_q <= '0; cut_q <= '0;
                sp_q <= '0; clk_q <= '0; cnt_q <= '0; rv_q <= '0;
              end
              ACT_CLEAR: row_vld_q <= '0;
              default: ;
            endcase
          end
        end
        // enter the next unvisited root, or set up the emit sweep once all are done
        S_ROOT: begin
          if (rv_end) begin
            ev_q <= '0;
            k_q <= '0;
          end else if (!visited_q[rv_idx]) begin
            visited_q[rv_idx] <= 1'b1;
            clk_q <= clk_inc;
            cur_v_q <= rv_idx;
            cur_scan_q <= '0;
            cur_low_q <= clk_inc;
            cur_entry_q <= clk_inc;
            has_par_q <= 1'b0;
            sp_q <= C_ONE;
            rc_q <= '0;
          end else begin
            rv_q <= rv_q + C_ONE;
          end
        end
        S_ROW: cur_row_q <= adj_row;
        // one neighbor per cycle, held by a descend or by the S_ET step of a visited neighbor
        S_SCAN: begin
          if (!scan_end) begin
            if (!skip_w && !w_vis) begin
              visited_q[w_idx] <= 1'b1;
              clk_q <= clk_inc;
              cur_v_q <= w_idx;
              cur_scan_q <= '0;
              cur_low_q <= clk_inc;
              cur_entry_q <= clk_inc;
              par_v_q <= cur_v_q;
              has_par_q <= 1'b1;
              sp_q <= sp_q + C_ONE;
              if (sp_q == C_ONE && rc_q != 2'd2) rc_q <= rc_q + 2'd1;
            end else begin
              cur_scan_q <= cur_scan_q + C_ONE;
            end
          end
        end
        S_ET: begin
          if (et_rdata < cur_low_q) cur_low_q <= et_rdata;
        end
        // leave the current vertex
        S_POP: begin
          sp_q <= sp_q - C_ONE;
          if (sp_q == C_ONE) begin
            rv_q <= rv_q + C_ONE;
            if (rc_q == 2'd2 && !cut_q[cur_v_q]) begin
              cut_q[cur_v_q] <= 1'b1;
              cnt_q <= cnt_q + C_ONE;
            end
          end
        end
        S_POP_RD: begin
          cur_v_q <= fr_v;
          cur_scan_q <= fr_scan;
          cur_entry_q <= fr_entry;
          cur_low_q <= (cur_low_q < fr_low) ? cur_low_q : fr_low;
          has_par_q <= (sp_q >= C_TWO);
          if (sp_q >= C_TWO && cur_low_q >= fr_entry && !cut_q[fr_v]) begin
            cut_q[fr_v] <= 1'b1;
            cnt_q <= cnt_q + C_ONE;
          end
        end
        S_POP_PAR: begin
          cur_row_q <= adj_row;
          if (has_par_q) par_v_q <= fr_v;
        end
        // emit sweep
        S_EMIT: begin
          if (cnt_q == '0) begin
            if (out_load) begin
              vertex_q <= '0; found_q <= 1'b0; count_q <= '0; last_q <= 1'b1;
            end
          end else if (!ev_end) begin
            if (!cut_q[ev_idx]) begin
              ev_q <= ev_q + C_ONE;
            end else if (out_load) begin
              vertex_q <= NODE_W'(ev_q) + NODE_W'(1);
              found_q <= 1'b1;
              count_q <= NODE_W'(cnt_q);
              last_q <= (k_q + C_ONE) == cnt_q;
              k_q <= k_q + C_ONE;
              ev_q <= ev_q + C_ONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid  = out_vld_q;
  assign res_o.vertex = vertex_q;
  assign res_o.found  = found_q;
  assign res_o.count  = count_q;
  assign res_o.last   = last_q;

  // adjacency rows, walk frames per stack level, entry times per vertex
  apf_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .re_i(adj_re), .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );
  apf_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_frame_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .re_i(fr_re), .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );
  apf_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_et_ram (
    .clk_i, .we_i(et_we), .waddr_i(et_waddr), .wdata_i(et_wdata),
    .re_i(et_re), .raddr_i(et_raddr), .rdata_o(et_rdata)
  );

  // checks
  `APF_ASSERT_NOW(a_sp_range, 1'b1, sp_q <= SP_MAX, "stack depth out of range")
  `APF_ASSERT_NOW(a_scan_stack, state_q == S_SCAN, sp_q != '0, "scan with empty stack")
  `APF_ASSERT_NOW(a_none_last, res_o.valid && !res_o.found, res_o.last && res_o.count == '0,
                  "no-cut result not final")
  `APF_ASSERT_NEXT(a_pop_root, state_q == S_POP && sp_q == C_ONE, sp_q == '0,
                   "root pop left stack")
endmodule

### rtl/apf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module apf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
